/* rtl/tcc_pkg.sv */
// shared widths, types and register codes for the temperature compensation block
package tcc_pkg;

    localparam int RAW_W    = 16;
    localparam int CAL_W    = 16;
    localparam int DIFF_W   = RAW_W + 1;
    localparam int PROD_W   = 2 * DIFF_W;
    localparam int SCALE_SH = 15;
    localparam int X1_W     = PROD_W - SCALE_SH - 1;
    localparam int DIVR_W   = X1_W + 1;
    localparam int DVS_W    = DIVR_W - 1;
    localparam int NUM_SH   = 11;
    localparam int DIV_Q_W  = CAL_W + NUM_SH;
    localparam int X2_W     = DIV_Q_W + 1;
    localparam int B5_W     = X2_W + 1;
    localparam int ROUND_AD = 8;
    localparam int OUT_SH   = 4;
    localparam int TEMP_W   = 24;
    localparam int IDX_W    = 2;

    localparam logic [IDX_W-1:0] REG_OFFSET_SCALE = 2'd0;
    localparam logic [IDX_W-1:0] REG_OFFSET       = 2'd1;
    localparam logic [IDX_W-1:0] REG_NUMERATOR    = 2'd2;
    localparam logic [IDX_W-1:0] REG_DIVISOR_BIAS = 2'd3;

    typedef struct packed {
        logic        [CAL_W-1:0] offset_scale;
        logic        [CAL_W-1:0] offset;
        logic signed [CAL_W-1:0] numerator;
        logic signed [CAL_W-1:0] divisor_bias;
    } t_cal;

    // state carried down the divider row
    typedef struct packed {
        logic signed [X1_W-1:0]    x1;
        logic        [DVS_W-1:0]   dvs;
        logic        [DVS_W-1:0]   rem;
        logic        [DIV_Q_W-1:0] dq;
        logic                      neg;
        logic                      zero;
    } t_div_data;

endpackage

/* rtl/tcc_front.sv */
// offset, scale multiply and divisor setup stages ahead of the divider row
module tcc_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic [tcc_pkg::RAW_W-1:0]    i_raw_temp,
    input  tcc_pkg::t_cal                i_cal,
    input  logic                         i_ready_dn,
    output logic                         o_ready,
    output logic                         o_valid,
    output tcc_pkg::t_div_data           o_data
);

    logic                                 r_v1, r_v2, r_v3;
    logic signed [tcc_pkg::DIFF_W-1:0]    r_diff;
    logic signed [tcc_pkg::PROD_W-1:0]    r_prod;
    tcc_pkg::t_div_data                   r_data;
    tcc_pkg::t_div_data                   n_data;
    logic                                 w_rdy1, w_rdy2, w_rdy3;
    logic signed [tcc_pkg::DIFF_W-1:0]    w_diff;
    logic signed [tcc_pkg::PROD_W-1:0]    w_prod;
    logic signed [tcc_pkg::X1_W-1:0]      w_x1;
    logic signed [tcc_pkg::DIVR_W-1:0]    w_divr;
    logic signed [tcc_pkg::DIVR_W-1:0]    w_divr_neg;
    logic signed [tcc_pkg::DIV_Q_W-1:0]   w_num;
    logic signed [tcc_pkg::DIV_Q_W-1:0]   w_num_neg;

    assign w_rdy3  = !r_v3 || i_ready_dn;
    assign w_rdy2  = !r_v2 || w_rdy3;
    assign w_rdy1  = !r_v1 || w_rdy2;
    assign o_ready = w_rdy1;
    assign o_valid = r_v3;
    assign o_data  = r_data;

    assign w_diff = $signed({1'b0, i_raw_temp}) - $signed({1'b0, i_cal.offset});
    assign w_prod = r_diff * $signed({1'b0, i_cal.offset_scale});

    always_comb begin
        // floor shift: keep the top bits of the product
        w_x1       = r_prod[tcc_pkg::PROD_W-2:tcc_pkg::SCALE_SH];
        w_divr     = $signed({w_x1[tcc_pkg::X1_W-1], w_x1})
                   + $signed({{(tcc_pkg::DIVR_W-tcc_pkg::CAL_W){i_cal.divisor_bias[
                       tcc_pkg::CAL_W-1]}}, i_cal.divisor_bias});
        w_divr_neg = -w_divr;
        w_num      = $signed({i_cal.numerator, {tcc_pkg::NUM_SH{1'b0}}});
        w_num_neg  = -w_num;
        n_data      = '0;
        n_data.x1   = w_x1;
        n_data.dvs  = w_divr[tcc_pkg::DIVR_W-1] ? w_divr_neg[tcc_pkg::DVS_W-1:0]
                                                : w_divr[tcc_pkg::DVS_W-1:0];
        n_data.dq   = i_cal.numerator[tcc_pkg::CAL_W-1] ? w_num_neg : w_num;
        n_data.neg  = i_cal.numerator[tcc_pkg::CAL_W-1] ^ w_divr[tcc_pkg::DIVR_W-1];
        n_data.zero = (w_divr == '0);
        n_data.rem  = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= i_valid;
            if (w_rdy2) r_v2 <= r_v1;
            if (w_rdy3) r_v3 <= r_v2;
        end
        if (w_rdy1 && i_valid) r_diff <= w_diff;
        if (w_rdy2 && r_v1)    r_prod <= w_prod;
        if (w_rdy3 && r_v2)    r_data <= n_data;
    end

endmodule

/* rtl/tcc_div_cell.sv */
// one restoring division step with its beat register
module tcc_div_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  tcc_pkg::t_div_data    i_data,
    input  logic                  i_ready_dn,
    output logic                  o_ready,
    output logic                  o_valid,
    output tcc_pkg::t_div_data    o_data
);

    logic                            r_valid;
    tcc_pkg::t_div_data              r_data;
    tcc_pkg::t_div_data              n_data;
    logic [tcc_pkg::DVS_W:0]         w_trial;
    logic [tcc_pkg::DVS_W:0]         w_sub;
    logic                            w_ge;

    assign o_ready = !r_valid || i_ready_dn;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_comb begin
        // bring down the next dividend bit, quotient bit shifts in at the bottom
        w_trial     = {i_data.rem, i_data.dq[tcc_pkg::DIV_Q_W-1]};
        w_sub       = w_trial - {1'b0, i_data.dvs};
        w_ge        = (w_trial >= {1'b0, i_data.dvs});
        n_data      = i_data;
        n_data.rem  = w_ge ? w_sub[tcc_pkg::DVS_W-1:0] : w_trial[tcc_pkg::DVS_W-1:0];
        n_data.dq   = {i_data.dq[tcc_pkg::DIV_Q_W-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) r_data <= n_data;
    end

endmodule

/* rtl/temperature_calibration_compensate.sv */
// top level: calibration registers, front stages, divider row and output stage
//
//  channel   direction  handshake           payload
//  input     in         i_valid / o_stall   i_raw_temp
//  result    out        o_valid / i_stall   o_temp_tenths, o_div_zero
//  config    in         i_cfg_we            i_cfg_index, i_cfg_data
//
// one beat per cycle in and out while i_stall is low; the path holds three front stages,
// one cell per quotient bit (27) and the output register
// every stage holds its own valid, so bubbles close up behind a stalled result
// synchronous active-low reset clears valids and the calibration words
module temperature_calibration_compensate (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [tcc_pkg::RAW_W-1:0]          i_raw_temp,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic signed [tcc_pkg::TEMP_W-1:0]  o_temp_tenths,
    output logic                               o_div_zero,
    input  logic                               i_cfg_we,
    input  logic [tcc_pkg::IDX_W-1:0]          i_cfg_index,
    input  logic [tcc_pkg::CAL_W-1:0]          i_cfg_data
);

    localparam int NCELL = tcc_pkg::DIV_Q_W;

    tcc_pkg::t_cal                        r_cal;
    tcc_pkg::t_div_data                   w_data  [0:NCELL];
    logic                                 w_valid [0:NCELL];
    logic                                 w_ready [0:NCELL];
    logic                                 w_front_ready;
    logic                                 w_out_ready;
    logic                                 r_out_valid;
    logic signed [tcc_pkg::TEMP_W-1:0]    r_temp;
    logic                                 r_zero;
    logic signed [tcc_pkg::X2_W-1:0]      w_q;
    logic signed [tcc_pkg::X2_W-1:0]      w_x2;
    logic signed [tcc_pkg::B5_W-1:0]      w_b5;
    logic signed [tcc_pkg::TEMP_W-1:0]    n_temp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                tcc_pkg::REG_OFFSET_SCALE: r_cal.offset_scale <= i_cfg_data;
                tcc_pkg::REG_OFFSET:       r_cal.offset       <= i_cfg_data;
                tcc_pkg::REG_NUMERATOR:    r_cal.numerator    <= $signed(i_cfg_data);
                tcc_pkg::REG_DIVISOR_BIAS: r_cal.divisor_bias <= $signed(i_cfg_data);
                default: r_cal <= r_cal;
            endcase
        end
    end

    assign o_stall = !w_front_ready;

    tcc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_raw_temp (i_raw_temp),
        .i_cal      (r_cal),
        .i_ready_dn (w_ready[0]),
        .o_ready    (w_front_ready),
        .o_valid    (w_valid[0]),
        .o_data     (w_data[0])
    );

    genvar g;
    generate
        for (g = 0; g < NCELL; g++) begin : g_cell
            tcc_div_cell u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_valid    (w_valid[g]),
                .i_data     (w_data[g]),
                .i_ready_dn (w_ready[g+1]),
                .o_ready    (w_ready[g]),
                .o_valid    (w_valid[g+1]),
                .o_data     (w_data[g+1])
            );
        end
    endgenerate

    assign w_out_ready    = !r_out_valid || !i_stall;
    assign w_ready[NCELL] = w_out_ready;

    always_comb begin
        w_q    = $signed({1'b0, w_data[NCELL].dq});
        w_x2   = w_data[NCELL].neg ? -w_q : w_q;
        w_b5   = $signed({{(tcc_pkg::B5_W-tcc_pkg::X1_W){w_data[NCELL].x1[
                     tcc_pkg::X1_W-1]}}, w_data[NCELL].x1})
               + $signed({w_x2[tcc_pkg::X2_W-1], w_x2})
               + $signed(tcc_pkg::B5_W'(tcc_pkg::ROUND_AD));
        // floor shift by four, result always fits the output width
        n_temp = w_data[NCELL].zero ? '0
               : w_b5[tcc_pkg::OUT_SH+tcc_pkg::TEMP_W-1:tcc_pkg::OUT_SH];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_ready) begin
            r_out_valid <= w_valid[NCELL];
        end
        if (w_out_ready && w_valid[NCELL]) begin
            r_temp <= n_temp;
            r_zero <= w_data[NCELL].zero;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_temp_tenths = r_temp;
    assign o_div_zero    = r_zero;

endmodule

/* tb/tb_temperature_calibration_compensate.sv */
`timescale 1ns / 100ps
// self-checking testbench for the temperature compensation block
module tb_temperature_calibration_compensate;

    localparam int LONG_HOLD   = 120;
    localparam int SETTLE_WAIT = 40;
    localparam int PHASES      = 6;
    localparam int PHASE_BEATS = 105;

    typedef struct packed {
        logic signed [tcc_pkg::TEMP_W-1:0] temp;
        logic                              div_zero;
    } t_temp_result;

    // calibration copy, temperature predictor and queue of pending temperatures
    class t_temp_board;
        logic        [tcc_pkg::CAL_W-1:0] scale;
        logic        [tcc_pkg::CAL_W-1:0] offset;
        logic signed [tcc_pkg::CAL_W-1:0] numer;
        logic signed [tcc_pkg::CAL_W-1:0] bias;
        t_temp_result                     expected_temps[$];
        int                               errors;

        function new();
            scale  = '0;
            offset = '0;
            numer  = '0;
            bias   = '0;
            errors = 0;
        endfunction

        function void set_reg(logic [tcc_pkg::IDX_W-1:0] idx,
                              logic [tcc_pkg::CAL_W-1:0] data);
            case (idx)
                tcc_pkg::REG_OFFSET_SCALE: scale  = data;
                tcc_pkg::REG_OFFSET:       offset = data;
                tcc_pkg::REG_NUMERATOR:    numer  = data;
                tcc_pkg::REG_DIVISOR_BIAS: bias   = data;
                default: ;
            endcase
        endfunction

        function t_temp_result compensate(logic [tcc_pkg::RAW_W-1:0] raw);
            longint       x1;
            longint       divisor;
            longint       b5;
            t_temp_result r;
            // longint shifts are arithmetic, division truncates toward zero
            x1 = ((longint'(raw) - longint'(offset)) * longint'(scale))
                 >>> tcc_pkg::SCALE_SH;
            divisor = x1 + longint'(bias);
            if (divisor == 0) begin
                r.temp     = '0;
                r.div_zero = 1'b1;
            end else begin
                b5 = x1 + (longint'(numer) * (longint'(1) << tcc_pkg::NUM_SH)) / divisor;
                b5 = (b5 + tcc_pkg::ROUND_AD) >>> tcc_pkg::OUT_SH;
                r.temp     = b5[tcc_pkg::TEMP_W-1:0];
                r.div_zero = 1'b0;
            end
            return r;
        endfunction

        function void note_reading(logic [tcc_pkg::RAW_W-1:0] raw);
            expected_temps.push_back(compensate(raw));
        endfunction

        function void check_temp(logic signed [tcc_pkg::TEMP_W-1:0] temp, logic div_zero);
            t_temp_result want;
            if (expected_temps.size() == 0) begin
                $error("unexpected result beat: temp_tenths %0d div_zero %0b",
                       temp, div_zero);
                errors++;
            end else begin
                want = expected_temps.pop_front();
                if (temp !== want.temp) begin
                    $error("temp_tenths mismatch: expected %0d actual %0d", want.temp, temp);
                    errors++;
                end
                if (div_zero !== want.div_zero) begin
                    $error("div_zero mismatch: expected %0b actual %0b",
                           want.div_zero, div_zero);
                    errors++;
                end
            end
        endfunction
    endclass

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              i_valid = 1'b0;
    logic                              o_stall;
    logic [tcc_pkg::RAW_W-1:0]         i_raw_temp = '0;
    logic                              o_valid;
    logic                              i_stall = 1'b0;
    logic signed [tcc_pkg::TEMP_W-1:0] o_temp_tenths;
    logic                              o_div_zero;
    logic                              i_cfg_we = 1'b0;
    logic [tcc_pkg::IDX_W-1:0]         i_cfg_index = '0;
    logic [tcc_pkg::CAL_W-1:0]         i_cfg_data = '0;

    t_temp_board board = new();
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_req = 0;
    int hold_seen = 0;
    int hold_left = 0;

    temperature_calibration_compensate dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_raw_temp    (i_raw_temp),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_temp_tenths (o_temp_tenths),
        .o_div_zero    (o_div_zero),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // receiver: random stall, or a long hold-off when one is requested
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_stall   <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_seen != hold_req) begin
            hold_seen <= hold_req;
            hold_left <= LONG_HOLD;
            i_stall   <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                board.note_reading(i_raw_temp);
            end
            if (o_valid && !i_stall) begin
                board.check_temp(o_temp_tenths, o_div_zero);
            end
        end
    end

    task automatic send_raw(input logic [tcc_pkg::RAW_W-1:0] raw);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_raw_temp <= raw;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic wait_drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (board.expected_temps.size() != 0) @(posedge i_clk);
    endtask

    task automatic put_reg(input logic [tcc_pkg::IDX_W-1:0] idx,
                           input logic [tcc_pkg::CAL_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        board.set_reg(idx, data);
    endtask

    task automatic load_cal(input logic [tcc_pkg::CAL_W-1:0] scale,
                            input logic [tcc_pkg::CAL_W-1:0] offset,
                            input logic signed [tcc_pkg::CAL_W-1:0] numer,
                            input logic signed [tcc_pkg::CAL_W-1:0] bias);
        put_reg(tcc_pkg::REG_OFFSET_SCALE, scale);
        put_reg(tcc_pkg::REG_OFFSET, offset);
        put_reg(tcc_pkg::REG_NUMERATOR, numer);
        put_reg(tcc_pkg::REG_DIVISOR_BIAS, bias);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        logic        [tcc_pkg::CAL_W-1:0] scale_w;
        logic        [tcc_pkg::CAL_W-1:0] offset_w;
        logic signed [tcc_pkg::CAL_W-1:0] numer_w;
        logic signed [tcc_pkg::CAL_W-1:0] bias_w;
        logic        [tcc_pkg::RAW_W-1:0] hot_raw;
        logic        [tcc_pkg::RAW_W-1:0] raw;
        longint                           hot_x1;
        int                               pick;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // calibration still at reset: divisor is zero for every reading
        send_raw(16'h0000);
        send_raw(16'hFFFF);
        wait_drain();

        load_cal(16'hFFFF, 16'h0000, 16'sh7FFF, 16'sh7FFF);
        send_raw(16'h0000);
        send_raw(16'hFFFF);
        send_raw(16'h5555);
        send_raw(16'hAAAA);
        wait_drain();

        // most negative x1 and numerator
        load_cal(16'hFFFF, 16'hFFFF, 16'sh8000, 16'sh8000);
        send_raw(16'h0000);
        send_raw(16'hFFFF);
        send_raw(16'h8000);
        wait_drain();

        // x1 equals raw - 1000; divisor hits zero at 1024 and +-1 around it
        load_cal(16'h8000, 16'd1000, 16'sd12347, -16'sd24);
        send_raw(16'd1024);
        send_raw(16'd1023);
        send_raw(16'd1025);
        send_raw(16'd0);
        send_raw(16'd999);
        send_raw(16'd1001);
        wait_drain();

        // small negative products floor away from zero
        load_cal(16'h0001, 16'hFFFF, 16'sd0, 16'sd5);
        send_raw(16'hFFFE);
        send_raw(16'h0000);
        wait_drain();

        for (int p = 0; p < PHASES; p++) begin
            if (p < 2) begin
                send_idle_pct  = 24;
                recv_stall_pct = 69;
            end else if (p < 4) begin
                send_idle_pct  = 69;
                recv_stall_pct = 24;
            end else begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end

            scale_w  = ($urandom_range(3) == 0) ? ($urandom_range(1) ? 16'hFFFF : 16'h0000)
                                                : 16'($urandom);
            offset_w = ($urandom_range(3) == 0) ? ($urandom_range(1) ? 16'hFFFF : 16'h0000)
                                                : 16'($urandom);
            numer_w  = ($urandom_range(3) == 0) ? ($urandom_range(1) ? 16'sh7FFF : 16'sh8000)
                                                : 16'($urandom);
            bias_w   = ($urandom_range(3) == 0) ? ($urandom_range(1) ? 16'sh7FFF : 16'sh8000)
                                                : 16'($urandom);
            // aim the bias so one reading near the offset gives a zero divisor
            hot_raw = offset_w + 16'($urandom_range(4000)) - 16'd2000;
            hot_x1  = ((longint'(hot_raw) - longint'(offset_w)) * longint'(scale_w))
                      >>> tcc_pkg::SCALE_SH;
            if ($urandom_range(3) != 0 && hot_x1 >= -32767 && hot_x1 <= 32768) begin
                bias_w = 16'(-hot_x1);
            end
            load_cal(scale_w, offset_w, numer_w, bias_w);

            for (int n = 0; n < PHASE_BEATS; n++) begin
                if (p == 4 && n == 10) begin
                    hold_req++;
                end
                if (p == 5 && n == PHASE_BEATS / 2) begin
                    wait_drain();
                end
                pick = $urandom_range(99);
                if (pick < 15) begin
                    raw = hot_raw;
                end else if (pick < 25) begin
                    raw = hot_raw + 16'($urandom_range(4)) - 16'd2;
                end else if (pick < 30) begin
                    raw = $urandom_range(1) ? 16'hFFFF : 16'h0000;
                end else begin
                    raw = 16'($urandom);
                end
                send_raw(raw);
            end
            wait_drain();
        end

        repeat (SETTLE_WAIT) @(posedge i_clk);
        if (board.errors == 0 && board.expected_temps.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
